>>> hw/rtl/fncu_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the face normal and culling unit
package fncu_pkg;

    localparam int COORD_W     = 16;
    localparam int SLOT_W      = 8;
    localparam int NORM_W      = 34;
    localparam int KEY_W       = 36;

    localparam int VTX_DEPTH   = 256;
    localparam int VTX_AW      = $clog2(VTX_DEPTH);

    // power of two, pointers wrap naturally
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_FACE   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OBS_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_Z     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_BACK = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    typedef struct packed {
        t_vertex a;
        t_vertex b;
        t_vertex c;
        t_vertex d;
        logic    is_quad;
    } t_face;

    typedef struct packed {
        logic signed [COORD_W-1:0] obs_x;
        logic signed [COORD_W-1:0] obs_y;
        logic signed [COORD_W-1:0] obs_z;
        logic                      show_back;
    } t_cfg;

    typedef struct packed {
        logic signed [NORM_W-1:0] z;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] x;
    } t_normal;

endpackage

>>> hw/rtl/face_normal_cull_unit.sv
`timescale 1ns / 1ps
// top level: stream ports, configuration registers, front, queue and back
// a face request is registered at the corner reads, the queue, back stages 1 to 5 and
// the output; one request per cycle while the queue has room and the output is not
// stalled, set by the four reads a cycle of the duplicated vertex store and the fully
// pipelined multiply stages; vertex writes give no result; reset clears control and
// configuration, the vertex store holds no reset value and must be written before use
module face_normal_cull_unit import fncu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vertex_slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c, corner_d
    input  logic [87:0]           s_axis_tdata,
    // cmd, is_quad
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // normal_x, normal_y, normal_z, depth_key, zero fill
    output logic [143:0]          m_axis_tdata,
    // face_visible
    output logic [0:0]            m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OBS_X:     r_cfg.obs_x     <= i_cfg_data;
                CFG_OBS_Y:     r_cfg.obs_y     <= i_cfg_data;
                CFG_OBS_Z:     r_cfg.obs_z     <= i_cfg_data;
                CFG_SHOW_BACK: r_cfg.show_back <= i_cfg_data[0];
            endcase
        end
    end

    t_vertex               w_coord;
    logic                  w_push;
    t_face                 w_push_face;
    t_face                 w_head_face;
    logic                  w_q_empty;
    logic [QUEUE_CW-1:0]   w_q_count;
    logic                  w_pop;
    t_normal               w_normal;
    logic                  w_visible;
    logic [KEY_W-1:0]      w_key;

    assign w_coord.x = s_axis_tdata[23:8];
    assign w_coord.y = s_axis_tdata[39:24];
    assign w_coord.z = s_axis_tdata[55:40];

    fncu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser[0]),
        .i_is_quad  (s_axis_tuser[1]),
        .i_slot     (s_axis_tdata[7:0]),
        .i_coord    (w_coord),
        .i_corner_a (s_axis_tdata[63:56]),
        .i_corner_b (s_axis_tdata[71:64]),
        .i_corner_c (s_axis_tdata[79:72]),
        .i_corner_d (s_axis_tdata[87:80]),
        .i_q_count  (w_q_count),
        .o_push     (w_push),
        .o_face     (w_push_face)
    );

    fncu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_face  (w_push_face),
        .i_pop   (w_pop),
        .o_face  (w_head_face),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    fncu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_face      (w_head_face),
        .o_q_pop     (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_normal    (w_normal),
        .o_visible   (w_visible),
        .o_depth_key (w_key)
    );

    assign m_axis_tdata = {6'd0, w_key, w_normal.z, w_normal.y, w_normal.x};
    assign m_axis_tuser = w_visible;

endmodule

>>> hw/rtl/fncu_front.sv
`timescale 1ns / 1ps
// front end: request intake, vertex store writes and four corner reads
module fncu_front import fncu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  logic                i_is_quad,
    input  logic [SLOT_W-1:0]   i_slot,
    input  t_vertex             i_coord,
    input  logic [SLOT_W-1:0]   i_corner_a,
    input  logic [SLOT_W-1:0]   i_corner_b,
    input  logic [SLOT_W-1:0]   i_corner_c,
    input  logic [SLOT_W-1:0]   i_corner_d,
    input  logic [QUEUE_CW-1:0] i_q_count,
    output logic                o_push,
    output t_face               o_face
);

    // two copies of the store, each with two read ports, give four reads a cycle
    t_vertex r_mem_ab [VTX_DEPTH];
    t_vertex r_mem_cd [VTX_DEPTH];

    t_vertex r_rd_a, r_rd_b, r_rd_c, r_rd_d;
    logic    r_f1_valid;
    logic    r_f1_quad;

    logic              w_accept;
    logic              w_wr_en;
    logic [QUEUE_CW:0] w_inflight;

    // reserve a queue slot for the read stage so it never has to stall
    assign w_inflight = (QUEUE_CW+1)'(i_q_count) + (QUEUE_CW+1)'(r_f1_valid);
    assign o_ready    = w_inflight < (QUEUE_CW+1)'(QUEUE_DEPTH);
    assign w_accept   = i_valid && o_ready;
    assign w_wr_en    = w_accept && (i_cmd == CMD_VERTEX);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_ab[i_slot[VTX_AW-1:0]] <= i_coord;
        end
        r_rd_a <= r_mem_ab[i_corner_a[VTX_AW-1:0]];
        r_rd_b <= r_mem_ab[i_corner_b[VTX_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_cd[i_slot[VTX_AW-1:0]] <= i_coord;
        end
        r_rd_c <= r_mem_cd[i_corner_c[VTX_AW-1:0]];
        r_rd_d <= r_mem_cd[i_corner_d[VTX_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= w_accept && (i_cmd == CMD_FACE);
        end
        r_f1_quad <= i_is_quad;
    end

    assign o_push         = r_f1_valid;
    assign o_face.a       = r_rd_a;
    assign o_face.b       = r_rd_b;
    assign o_face.c       = r_rd_c;
    assign o_face.d       = r_rd_d;
    assign o_face.is_quad = r_f1_quad;

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_valid |-> (i_q_count < QUEUE_CW'(QUEUE_DEPTH)))
        else $error("front pushed into a full queue");

endmodule

>>> hw/rtl/fncu_queue.sv
`timescale 1ns / 1ps
// short face queue between front end and arithmetic back end
module fncu_queue import fncu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_face               i_face,
    input  logic                i_pop,
    output t_face               o_face,
    output logic                o_empty,
    output logic [QUEUE_CW-1:0] o_count
);

    t_face               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_face;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QUEUE_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_face  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + QUEUE_CW'(1)))
        else $error("queue lost a push");

endmodule

>>> hw/rtl/fncu_back.sv
`timescale 1ns / 1ps
// back end: cross product normal, quad retry, facing test and depth key
module fncu_back import fncu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_empty,
    input  t_face            i_face,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output t_normal          o_normal,
    output logic             o_visible,
    output logic [KEY_W-1:0] o_depth_key
);

    localparam int DIF_W = COORD_W + 1;
    localparam int MID_W = COORD_W + 2;
    localparam int PRD_W = 2 * DIF_W;
    localparam int DXP_W = DIF_W + NORM_W;
    localparam int DOT_W = DXP_W + 2;

    function automatic logic signed [DIF_W-1:0] sx17(input logic signed [COORD_W-1:0] v);
        return {v[COORD_W-1], v};
    endfunction

    function automatic logic signed [MID_W-1:0] sx18(input logic signed [COORD_W-1:0] v);
        return {{2{v[COORD_W-1]}}, v};
    endfunction

    logic back_en;

    logic r_b1_valid, r_b2_valid, r_b3_valid, r_b4_valid, r_b5_valid, r_out_valid;

    // stage 1: edge vectors, observer offset, doubled midpoint offset
    logic signed [DIF_W-1:0] r_b1_ux, r_b1_uy, r_b1_uz;
    logic signed [DIF_W-1:0] r_b1_vx, r_b1_vy, r_b1_vz;
    logic signed [DIF_W-1:0] r_b1_wx, r_b1_wy, r_b1_wz;
    logic signed [DIF_W-1:0] r_b1_ox, r_b1_oy, r_b1_oz;
    logic signed [MID_W-1:0] r_b1_mx, r_b1_my, r_b1_mz;
    logic                    r_b1_quad;

    // stage 2: cross product terms for both corner sets, squares
    logic signed [PRD_W-1:0] r_b2_p1x, r_b2_q1x, r_b2_p1y, r_b2_q1y, r_b2_p1z, r_b2_q1z;
    logic signed [PRD_W-1:0] r_b2_p2x, r_b2_q2x, r_b2_p2y, r_b2_q2y, r_b2_p2z, r_b2_q2z;
    logic [KEY_W-1:0]        r_b2_sqx, r_b2_sqy, r_b2_sqz;
    logic signed [DIF_W-1:0] r_b2_ox, r_b2_oy, r_b2_oz;
    logic                    r_b2_quad;

    // stage 3: both normals, depth key
    t_normal                 r_b3_n1, r_b3_n2;
    logic [KEY_W-1:0]        r_b3_key;
    logic signed [DIF_W-1:0] r_b3_ox, r_b3_oy, r_b3_oz;
    logic                    r_b3_quad;

    // stage 4: chosen normal
    t_normal                 r_b4_n;
    logic [KEY_W-1:0]        r_b4_key;
    logic signed [DIF_W-1:0] r_b4_ox, r_b4_oy, r_b4_oz;

    // stage 5: dot product terms
    logic signed [DXP_W-1:0] r_b5_dx, r_b5_dy, r_b5_dz;
    t_normal                 r_b5_n;
    logic [KEY_W-1:0]        r_b5_key;

    t_normal                 r_out_n;
    logic [KEY_W-1:0]        r_out_key;
    logic                    r_out_vis;

    logic signed [DOT_W-1:0] w_dot;

    assign back_en = !r_out_valid || i_ready;
    assign o_q_pop = back_en && !i_q_empty;
    assign w_dot   = DOT_W'(r_b5_dx) + DOT_W'(r_b5_dy) + DOT_W'(r_b5_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_b4_valid  <= 1'b0;
            r_b5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (back_en) begin
            r_b1_valid  <= !i_q_empty;
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_b4_valid  <= r_b3_valid;
            r_b5_valid  <= r_b4_valid;
            r_out_valid <= r_b5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_en) begin
            r_b1_ux   <= sx17(i_face.b.x) - sx17(i_face.a.x);
            r_b1_uy   <= sx17(i_face.b.y) - sx17(i_face.a.y);
            r_b1_uz   <= sx17(i_face.b.z) - sx17(i_face.a.z);
            r_b1_vx   <= sx17(i_face.c.x) - sx17(i_face.a.x);
            r_b1_vy   <= sx17(i_face.c.y) - sx17(i_face.a.y);
            r_b1_vz   <= sx17(i_face.c.z) - sx17(i_face.a.z);
            r_b1_wx   <= sx17(i_face.d.x) - sx17(i_face.a.x);
            r_b1_wy   <= sx17(i_face.d.y) - sx17(i_face.a.y);
            r_b1_wz   <= sx17(i_face.d.z) - sx17(i_face.a.z);
            r_b1_ox   <= sx17(i_face.a.x) - sx17(i_cfg.obs_x);
            r_b1_oy   <= sx17(i_face.a.y) - sx17(i_cfg.obs_y);
            r_b1_oz   <= sx17(i_face.a.z) - sx17(i_cfg.obs_z);
            r_b1_mx   <= sx18(i_face.a.x) + sx18(i_face.c.x) - (sx18(i_cfg.obs_x) <<< 1);
            r_b1_my   <= sx18(i_face.a.y) + sx18(i_face.c.y) - (sx18(i_cfg.obs_y) <<< 1);
            r_b1_mz   <= sx18(i_face.a.z) + sx18(i_face.c.z) - (sx18(i_cfg.obs_z) <<< 1);
            r_b1_quad <= i_face.is_quad;

            // (B-A) x (C-A)
            r_b2_p1x  <= PRD_W'(r_b1_uy) * PRD_W'(r_b1_vz);
            r_b2_q1x  <= PRD_W'(r_b1_uz) * PRD_W'(r_b1_vy);
            r_b2_p1y  <= PRD_W'(r_b1_uz) * PRD_W'(r_b1_vx);
            r_b2_q1y  <= PRD_W'(r_b1_ux) * PRD_W'(r_b1_vz);
            r_b2_p1z  <= PRD_W'(r_b1_ux) * PRD_W'(r_b1_vy);
            r_b2_q1z  <= PRD_W'(r_b1_uy) * PRD_W'(r_b1_vx);
            // (C-A) x (D-A) for the degenerate quad retry
            r_b2_p2x  <= PRD_W'(r_b1_vy) * PRD_W'(r_b1_wz);
            r_b2_q2x  <= PRD_W'(r_b1_vz) * PRD_W'(r_b1_wy);
            r_b2_p2y  <= PRD_W'(r_b1_vz) * PRD_W'(r_b1_wx);
            r_b2_q2y  <= PRD_W'(r_b1_vx) * PRD_W'(r_b1_wz);
            r_b2_p2z  <= PRD_W'(r_b1_vx) * PRD_W'(r_b1_wy);
            r_b2_q2z  <= PRD_W'(r_b1_vy) * PRD_W'(r_b1_wx);
            r_b2_sqx  <= KEY_W'(KEY_W'(r_b1_mx) * KEY_W'(r_b1_mx));
            r_b2_sqy  <= KEY_W'(KEY_W'(r_b1_my) * KEY_W'(r_b1_my));
            r_b2_sqz  <= KEY_W'(KEY_W'(r_b1_mz) * KEY_W'(r_b1_mz));
            r_b2_ox   <= r_b1_ox;
            r_b2_oy   <= r_b1_oy;
            r_b2_oz   <= r_b1_oz;
            r_b2_quad <= r_b1_quad;

            r_b3_n1.x <= r_b2_p1x - r_b2_q1x;
            r_b3_n1.y <= r_b2_p1y - r_b2_q1y;
            r_b3_n1.z <= r_b2_p1z - r_b2_q1z;
            r_b3_n2.x <= r_b2_p2x - r_b2_q2x;
            r_b3_n2.y <= r_b2_p2y - r_b2_q2y;
            r_b3_n2.z <= r_b2_p2z - r_b2_q2z;
            r_b3_key  <= r_b2_sqx + r_b2_sqy + r_b2_sqz;
            r_b3_ox   <= r_b2_ox;
            r_b3_oy   <= r_b2_oy;
            r_b3_oz   <= r_b2_oz;
            r_b3_quad <= r_b2_quad;

            // exact arithmetic, so degenerate means all three components zero
            r_b4_n    <= (r_b3_quad && (r_b3_n1 == '0)) ? r_b3_n2 : r_b3_n1;
            r_b4_key  <= r_b3_key;
            r_b4_ox   <= r_b3_ox;
            r_b4_oy   <= r_b3_oy;
            r_b4_oz   <= r_b3_oz;

            r_b5_dx   <= DXP_W'(r_b4_ox) * DXP_W'(r_b4_n.x);
            r_b5_dy   <= DXP_W'(r_b4_oy) * DXP_W'(r_b4_n.y);
            r_b5_dz   <= DXP_W'(r_b4_oz) * DXP_W'(r_b4_n.z);
            r_b5_n    <= r_b4_n;
            r_b5_key  <= r_b4_key;

            r_out_n   <= r_b5_n;
            r_out_key <= r_b5_key;
            r_out_vis <= i_cfg.show_back || w_dot[DOT_W-1];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_normal    = r_out_n;
    assign o_visible   = r_out_vis;
    assign o_depth_key = r_out_key;

    a_triangle_keeps_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_en && r_b3_valid && !r_b3_quad) |=> (r_b4_n == $past(r_b3_n1)))
        else $error("triangle took the retry normal");

endmodule
